// ===== rtl/rwl_pkg.sv =====
// Shared types and constants of the reflex weight learner.
package rwl_pkg;

   // register indexes on the configuration port
   localparam logic [1:0] CSR_MODE  = 2'd0;
   localparam logic [1:0] CSR_LIMIT = 2'd1;
   localparam logic [1:0] CSR_RATE  = 2'd2;

   // learning rule codes held in the mode register
   localparam logic [1:0] MODE_ONE_SIDED = 2'd0;
   localparam logic [1:0] MODE_SYMMETRIC = 2'd1;
   localparam logic [1:0] MODE_CROSS     = 2'd2;
   localparam logic [1:0] MODE_COMBINED  = 2'd3;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;         // capture an accepted item, form flags and difference
      logic mul_first;    // product of sample and reflex difference
      logic mul_second;   // scale by the learning rate, keep the Q19.16 term
      logic sel_b;        // operate on sample_b instead of sample_a
      logic update;       // apply terms to weights, load the result register
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic combined;     // mode needs a second term for sample_b
   } status_type;

endpackage

// ===== rtl/reflex_weight_learner.sv =====
// Top level of the reflex weight learner: controller plus datapath.
//
// Each request item carries one averaged angle sample (or a roll and pitch
// pair). The block decides whether the threshold reflex fires, updates
// up to four saturating Q15.16 weights by rate * sample * (reflex -
// previous reflex), and returns one response item with the four weights,
// the new reflex value and the reflex flag.
// One item is worked on at a time. The steps are: take the item; two passes
// of the single shared multiplier per term (sample times difference, then
// times the learning rate), one term for sample_a, plus one for sample_b
// in mode 3; then update the weights and load the response register.
// A finished response waits in its own register; the next request is taken
// meanwhile, and only its weight update step waits for the receiver.
// Reset clears the weights, the stored reflex and all configuration.
// The user must write configuration through csr_we / csr_index / csr_wdata
// while idle (not enforced); indexes beyond the register list are ignored.
module reflex_weight_learner import rwl_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   // configuration write port
   input  logic          csr_we,
   input  logic [1:0]    csr_index,
   input  logic [15:0]   csr_wdata,
   // request channel
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [31:0]   req_tdata,   // sample_a[15:0], sample_b[31:16]
   // response channel
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [151:0]  rsp_tdata    // weight_a0[31:0], weight_a1[63:32],
                                      // weight_b0[95:64], weight_b1[127:96],
                                      // reflex_value[144:128],
                                      // reflex_active[145], zero[151:146]
);

   cmd_type      cmd;
   status_type   status;
   logic [145:0] out_data;

   rwl_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rwl_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .in_sample_a (req_tdata[15:0]),
      .in_sample_b (req_tdata[31:16]),
      .cmd         (cmd),
      .status      (status),
      .out_data    (out_data)
   );

   assign rsp_tdata = {6'd0, out_data};

endmodule

// ===== rtl/rwl_datapath.sv =====
// Datapath: configuration registers, reflex decision, shared multiplier, weights.
module rwl_datapath import rwl_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_we,
   input  logic [1:0]    csr_index,
   input  logic [15:0]   csr_wdata,
   input  logic [15:0]   in_sample_a,
   input  logic [15:0]   in_sample_b,
   input  cmd_type       cmd,
   output status_type    status,
   output logic [145:0]  out_data
);

   // configuration
   logic [1:0]  mode_ff;
   logic [14:0] limit_ff;
   logic [15:0] rate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_ONE_SIDED;
         limit_ff <= 15'd0;
         rate_ff  <= 16'd0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MODE:  mode_ff  <= csr_wdata[1:0];
            CSR_LIMIT: limit_ff <= csr_wdata[14:0];
            CSR_RATE:  rate_ff  <= csr_wdata;
            default:   ;
         endcase
      end
   end

   assign status.combined = (mode_ff == MODE_COMBINED);

   // learner state
   logic signed [31:0] weights_ff [4];
   logic signed [16:0] last_ff;

   // per-item registers
   logic signed [15:0] a_ff, b_ff;
   logic signed [17:0] diff_ff;
   logic signed [16:0] nr_ff;
   logic               act_ff;
   logic               pos_ff;
   logic signed [33:0] prod_ff;
   logic signed [35:0] da_ff, db_ff;

   // reflex decision on the incoming item
   logic signed [16:0] a17, b17, lim17, abs_a, abs_b, m17;
   logic               a_gt, a_lt, over_a, over_b;
   logic signed [16:0] nr_in;
   logic signed [17:0] diff_in;
   logic               act_in;

   always_comb begin
      a17    = 17'(signed'(in_sample_a));
      b17    = 17'(signed'(in_sample_b));
      lim17  = {2'b00, limit_ff};
      abs_a  = a17[16] ? -a17 : a17;
      abs_b  = b17[16] ? -b17 : b17;
      a_gt   = a17 > lim17;
      a_lt   = a17 < -lim17;
      over_a = abs_a > lim17;
      over_b = abs_b > lim17;
      m17    = (over_a ? a17 : 17'sd0) + (over_b ? b17 : 17'sd0);
      case (mode_ff)
         MODE_ONE_SIDED, MODE_CROSS: act_in = a_gt | a_lt;
         MODE_SYMMETRIC:             act_in = abs_a >= lim17;
         MODE_COMBINED:              act_in = !(over_a && over_b);
         default:                    act_in = 1'b0;
      endcase
      if (mode_ff == MODE_COMBINED) begin
         nr_in   = m17;
         diff_in = 18'(m17) - 18'(last_ff);
      end else begin
         nr_in   = act_in ? a17 : 17'sd0;
         diff_in = 18'(a17) - 18'(last_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         a_ff    <= signed'(in_sample_a);
         b_ff    <= signed'(in_sample_b);
         diff_ff <= diff_in;
         nr_ff   <= nr_in;
         act_ff  <= act_in;
         pos_ff  <= !a_gt;
      end
   end

   // shared multiplier: sample times difference, then times the rate
   logic signed [33:0] mul_x;
   logic signed [17:0] mul_y;
   logic signed [51:0] mul_p;

   always_comb begin
      if (cmd.mul_first) begin
         mul_x = 34'(cmd.sel_b ? b_ff : a_ff);
         mul_y = diff_ff;
      end else begin
         mul_x = prod_ff;
         mul_y = {2'b00, rate_ff};
      end
      mul_p = 52'(mul_x) * 52'(mul_y);
   end

   // arithmetic shift is the floor of the division by 2^16
   always_ff @(posedge clock) begin
      if (cmd.mul_first) prod_ff <= mul_p[33:0];
      if (cmd.mul_second) begin
         if (cmd.sel_b) db_ff <= mul_p[51:16];
         else           da_ff <= mul_p[51:16];
      end
   end

   // weight plus or minus a term, saturated to 32 bits
   function automatic logic signed [31:0] sat_add(input logic signed [31:0] w,
                                                  input logic signed [35:0] d,
                                                  input logic sub);
      logic signed [36:0] v;
      begin
         v = 37'(w) + (sub ? -37'(d) : 37'(d));
         if (v > 37'sh0_7FFF_FFFF)       sat_add = 32'sh7FFF_FFFF;
         else if (v < -37'sh0_8000_0000) sat_add = -32'sh8000_0000;
         else                            sat_add = v[31:0];
      end
   endfunction

   // weight update under the selected rule
   logic signed [31:0] w_new [4];

   always_comb begin
      for (int i = 0; i < 4; i++) w_new[i] = weights_ff[i];
      case (mode_ff)
         MODE_ONE_SIDED: begin
            if (act_ff) begin
               if (!pos_ff) w_new[0] = sat_add(weights_ff[0], da_ff, 1'b0);
               else         w_new[1] = sat_add(weights_ff[1], da_ff, 1'b0);
            end
         end
         MODE_SYMMETRIC: begin
            if (act_ff) begin
               w_new[0] = sat_add(weights_ff[0], da_ff, 1'b0);
               w_new[1] = sat_add(weights_ff[1], da_ff, 1'b1);
            end
         end
         MODE_CROSS: begin
            if (act_ff) begin
               w_new[0] = sat_add(weights_ff[0], da_ff, pos_ff);
               w_new[1] = sat_add(weights_ff[1], da_ff, !pos_ff);
            end
         end
         MODE_COMBINED: begin
            w_new[0] = sat_add(weights_ff[0], da_ff, 1'b0);
            w_new[1] = sat_add(weights_ff[1], da_ff, 1'b1);
            w_new[2] = sat_add(weights_ff[2], db_ff, 1'b0);
            w_new[3] = sat_add(weights_ff[3], db_ff, 1'b0);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) weights_ff[i] <= 32'sd0;
         last_ff <= 17'sd0;
      end else if (cmd.update) begin
         for (int i = 0; i < 4; i++) weights_ff[i] <= w_new[i];
         last_ff <= nr_ff;
      end
   end

   // result register, holds while the receiver stalls
   logic [145:0] out_ff;

   always_ff @(posedge clock) begin
      if (cmd.update)
         out_ff <= {act_ff, nr_ff, w_new[3], w_new[2], w_new[1], w_new[0]};
   end

   assign out_data = out_ff;

endmodule

// ===== rtl/rwl_controller.sv =====
// Controller: sequences load, multiplier passes, update and result handshake.
module rwl_controller import rwl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  status_type  status,
   output cmd_type     cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MA1  = 3'd1;
   localparam logic [2:0] ST_MA2  = 3'd2;
   localparam logic [2:0] ST_MB1  = 3'd3;
   localparam logic [2:0] ST_MB2  = 3'd4;
   localparam logic [2:0] ST_UPD  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       valid_ff, valid_in;
   logic       out_free;

   assign out_free = !valid_ff || rsp_tready;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_MA1;
            end
         end
         ST_MA1: begin
            cmd.mul_first = 1'b1;
            state_in      = ST_MA2;
         end
         ST_MA2: begin
            cmd.mul_second = 1'b1;
            state_in       = status.combined ? ST_MB1 : ST_UPD;
         end
         ST_MB1: begin
            cmd.mul_first = 1'b1;
            cmd.sel_b     = 1'b1;
            state_in      = ST_MB2;
         end
         ST_MB2: begin
            cmd.mul_second = 1'b1;
            cmd.sel_b      = 1'b1;
            state_in       = ST_UPD;
         end
         ST_UPD: begin
            // wait until the result register can take the new item
            if (out_free) begin
               cmd.update = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // result valid flag
   always_comb begin
      if (cmd.update)      valid_in = 1'b1;
      else if (rsp_tready) valid_in = 1'b0;
      else                 valid_in = valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;

endmodule
